// ----- src/tun_pkg.sv -----
// Shared constants, widths and types for the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;
   localparam int COORD_WIDTH_DEF   = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int OUT_WIDTH         = 16;
   localparam int DIFF_MAX          = 31;          // reduced difference width incl. sign
   localparam int NORM_WIDTH        = 31;          // normalized magnitude bits
   localparam int SUM_WIDTH         = 64;          // sum of squares
   localparam int ROOT_WIDTH        = 32;
   localparam int SQRT_STEPS        = 32;          // one result bit per cell

   typedef struct packed {
      logic [NORM_WIDTH-1:0] mag_x;
      logic [NORM_WIDTH-1:0] mag_y;
      logic [NORM_WIDTH-1:0] mag_z;
      logic                  neg_x;
      logic                  neg_y;
      logic                  neg_z;
      logic                  degen;
   } vec_type;

   // Token carried by the root cells.
   typedef struct packed {
      logic                  valid;
      vec_type               vec;
      logic [SUM_WIDTH-1:0]  rem;
      logic [ROOT_WIDTH-1:0] root;
      logic [SUM_WIDTH-1:0]  src;
   } sqrt_tok_type;
endpackage

// ----- src/tun_stream_if.sv -----
// Valid/ready stream interface with a generic payload.
`timescale 1ns / 1ps
interface tun_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tun_sqrt_cell.sv -----
// One restoring square-root cell: resolves one root bit per stage.
`timescale 1ns / 1ps
module tun_sqrt_cell import tun_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  sqrt_tok_type tok_i,
   output sqrt_tok_type tok_o
);
   sqrt_tok_type tok_ff, tok_in;
   logic [SUM_WIDTH+1:0] rem_sh, trial;

   always_comb begin
      tok_in = tok_i;
      rem_sh = {tok_i.rem, tok_i.src[SUM_WIDTH-1 -: 2]};
      trial  = {{(SUM_WIDTH-ROOT_WIDTH){1'b0}}, tok_i.root, 2'b01};
      tok_in.src = {tok_i.src[SUM_WIDTH-3:0], 2'b00};
      if (rem_sh >= trial) begin
         tok_in.rem  = SUM_WIDTH'(rem_sh - trial);
         tok_in.root = {tok_i.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         tok_in.rem  = SUM_WIDTH'(rem_sh);
         tok_in.root = {tok_i.root[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff.valid <= tok_in.valid;
      end
      if (advance) begin
         tok_ff.vec  <= tok_in.vec;
         tok_ff.rem  <= tok_in.rem;
         tok_ff.root <= tok_in.root;
         tok_ff.src  <= tok_in.src;
      end
   end
   assign tok_o = tok_ff;
endmodule

// ----- src/tun_div_cell.sv -----
// One restoring divider cell: one quotient bit per stage, three lanes.
`timescale 1ns / 1ps
module tun_div_cell import tun_pkg::*; #(
   parameter int QW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_i,
   input  logic [3*(ROOT_WIDTH+1)-1:0] rem_i,
   input  logic [3*QW-1:0]       quo_i,
   input  logic [3*(NORM_WIDTH+QW)-1:0] num_i,
   input  logic [ROOT_WIDTH-1:0] div_i,
   input  vec_type               vec_i,
   output logic                  valid_o,
   output logic [3*(ROOT_WIDTH+1)-1:0] rem_o,
   output logic [3*QW-1:0]       quo_o,
   output logic [3*(NORM_WIDTH+QW)-1:0] num_o,
   output logic [ROOT_WIDTH-1:0] div_o,
   output vec_type               vec_o
);
   localparam int RW = ROOT_WIDTH + 1;
   localparam int NW = NORM_WIDTH + QW;
   logic                 valid_ff;
   logic [3*RW-1:0]      rem_ff, rem_in;
   logic [3*QW-1:0]      quo_ff, quo_in;
   logic [3*NW-1:0]      num_ff, num_in;
   logic [ROOT_WIDTH-1:0] div_ff;
   vec_type              vec_ff;
   logic [RW:0]          sh [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = {rem_i[k*RW +: RW], num_i[k*NW + NW - 1]};
         num_in[k*NW +: NW] = {num_i[k*NW +: NW-1], 1'b0};
         if (sh[k] >= {2'b00, div_i}) begin
            rem_in[k*RW +: RW] = RW'(sh[k] - {2'b00, div_i});
            quo_in[k*QW +: QW] = {quo_i[k*QW +: QW-1], 1'b1};
         end else begin
            rem_in[k*RW +: RW] = RW'(sh[k]);
            quo_in[k*QW +: QW] = {quo_i[k*QW +: QW-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         num_ff <= num_in;
         div_ff <= div_i;
         vec_ff <= vec_i;
      end
   end
   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;
   assign num_o   = num_ff;
   assign div_o   = div_ff;
   assign vec_o   = vec_ff;
endmodule

// ----- src/tun_front.sv -----
// Front pipeline: differences, cross product, magnitudes and block normalize.
`timescale 1ns / 1ps
module tun_front import tun_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_i,
   input  logic [9*COORD_WIDTH-1:0] coords_i,
   output logic                   valid_o,
   output vec_type                vec_o
);
   localparam int DW  = (COORD_WIDTH + 1 > DIFF_MAX) ? DIFF_MAX : COORD_WIDTH + 1;
   localparam int RSH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
   localparam int PW  = 2 * DW;
   localparam int CW  = PW + 1;
   localparam int LW  = 7;

   // stage 1: differences
   logic signed [DW-1:0] v1_ff [3], v2_ff [3], v1_in [3], v2_in [3];
   logic signed [COORD_WIDTH:0] d1 [3], d2 [3];

   function automatic logic signed [DW-1:0] reduce(input logic signed [COORD_WIDTH:0] d);
      logic [COORD_WIDTH:0] m;
      logic [COORD_WIDTH:0] r;
      m = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(1)+(COORD_WIDTH+1)'(~d) : d;
      r = m >> RSH;
      r = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(~r + 1'b1) : r;
      return r[DW-1:0];
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d1[k] = $signed({coords_i[k*COORD_WIDTH + COORD_WIDTH-1], coords_i[k*COORD_WIDTH +: COORD_WIDTH]})
               - $signed({coords_i[(3+k)*COORD_WIDTH + COORD_WIDTH-1], coords_i[(3+k)*COORD_WIDTH +: COORD_WIDTH]});
         d2[k] = $signed({coords_i[(6+k)*COORD_WIDTH + COORD_WIDTH-1], coords_i[(6+k)*COORD_WIDTH +: COORD_WIDTH]})
               - $signed({coords_i[(3+k)*COORD_WIDTH + COORD_WIDTH-1], coords_i[(3+k)*COORD_WIDTH +: COORD_WIDTH]});
         v1_in[k] = reduce(d1[k]);
         v2_in[k] = reduce(d2[k]);
      end
   end

   // stage 2: six products
   logic signed [PW-1:0] p_ff [6];
   // stage 3: cross components
   logic signed [CW-1:0] n_ff [3];
   // stage 4: magnitudes, signs
   logic [CW-2:0] mag_ff [3];
   logic [2:0]    neg_ff;
   logic [CW-2:0] mx;
   // stage 5: leading-one position, magnitudes carried along
   logic [LW-1:0] len_ff, len_in;
   logic [CW-2:0] mag2_ff [3];
   logic [2:0]    neg2_ff;
   // stage 6: normalized
   vec_type vec_ff, vec_in;

   always_comb begin
      mx = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int i = 0; i < CW - 1; i++) begin
         if (mx[i]) len_in = LW'(i + 1);
      end
   end

   function automatic logic [NORM_WIDTH-1:0] norm(input logic [CW-2:0] m,
                                                   input logic [LW-1:0] len);
      logic [CW+NORM_WIDTH-1:0] w;
      w = {{(NORM_WIDTH+1){1'b0}}, m} << NORM_WIDTH;
      w = w >> len;
      return w[NORM_WIDTH-1:0];
   endfunction

   always_comb begin
      vec_in.mag_x = norm(mag2_ff[0], len_ff);
      vec_in.mag_y = norm(mag2_ff[1], len_ff);
      vec_in.mag_z = norm(mag2_ff[2], len_ff);
      vec_in.neg_x = neg2_ff[0];
      vec_in.neg_y = neg2_ff[1];
      vec_in.neg_z = neg2_ff[2];
      vec_in.degen = (len_ff == '0);
   end

   logic [5:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], valid_i};
      end
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            v1_ff[k] <= v1_in[k];
            v2_ff[k] <= v2_in[k];
         end
         p_ff[0] <= v2_ff[1] * v1_ff[2];
         p_ff[1] <= v2_ff[2] * v1_ff[1];
         p_ff[2] <= v2_ff[2] * v1_ff[0];
         p_ff[3] <= v2_ff[0] * v1_ff[2];
         p_ff[4] <= v2_ff[0] * v1_ff[1];
         p_ff[5] <= v2_ff[1] * v1_ff[0];
         n_ff[0] <= CW'(p_ff[0]) - CW'(p_ff[1]);
         n_ff[1] <= CW'(p_ff[2]) - CW'(p_ff[3]);
         n_ff[2] <= CW'(p_ff[4]) - CW'(p_ff[5]);
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= n_ff[k][CW-1];
            mag_ff[k] <= n_ff[k][CW-1] ? (CW-1)'(-n_ff[k]) : n_ff[k][CW-2:0];
            mag2_ff[k] <= mag_ff[k];
         end
         neg2_ff <= neg_ff;
         len_ff <= len_in;
         vec_ff <= vec_in;
      end
   end
   assign valid_o = vld_ff[5];
   assign vec_o   = vec_ff;
endmodule

// ----- src/triangle_unit_normal.sv -----
// Top level of the triangle unit normal pipeline.
`timescale 1ns / 1ps
// Triangle unit normal.
// req carries one transaction per triangle: points a, b, c as signed Q8.8.
// rsp returns one transaction per triangle: the unit normal of (c-b)x(a-b)
// in signed Q1.14 plus a degenerate flag (zero cross product, normal zero).
// Structure: a front pipeline (differences, products, cross sum, magnitude,
// leading-one, block normalize), a sum-of-squares pair of stages, a chain of
// 32 square root cells resolving one root bit each, and a chain of divider
// cells, one quotient bit each, running the three components side by side.
// Throughput: one transaction per clock while rsp.ready keeps the chain moving.
// The path from request to response holds 6 + 2 + 32 + (OUT_FRAC_BITS + 2) + 1 =
// 57 register stages.
// When the output register holds a result and rsp.ready is low, the whole
// chain freezes and req.ready drops; a full pipeline with a stalled
// receiver holds every transaction in place, none lost.
// Reset clears all valid bits; payload registers are left as they are.
module triangle_unit_normal import tun_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   tun_stream_if.sink   req,
   tun_stream_if.source rsp
);
   localparam int QW = OUT_FRAC_BITS + 2;
   localparam int RW = ROOT_WIDTH + 1;
   localparam int NW = NORM_WIDTH + QW;

   // whole chain advances unless the output holds an untaken result
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   logic    f_valid;
   vec_type f_vec;
   tun_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset, .advance,
      .valid_i (req.valid),
      .coords_i(req.data[9*COORD_WIDTH-1:0]),
      .valid_o (f_valid),
      .vec_o   (f_vec)
   );

   // sum of squares: squares then add
   logic [1:0] sq_valid_ff;
   logic [2*NORM_WIDTH-1:0] sq_ff [3];
   logic [SUM_WIDTH-1:0] sum_ff;
   vec_type sq_vec_ff [2];
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (advance) begin
         sq_valid_ff <= {sq_valid_ff[0], f_valid};
      end
      if (advance) begin
         sq_ff[0] <= f_vec.mag_x * f_vec.mag_x;
         sq_ff[1] <= f_vec.mag_y * f_vec.mag_y;
         sq_ff[2] <= f_vec.mag_z * f_vec.mag_z;
         sum_ff <= SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
         sq_vec_ff[0] <= f_vec;
         sq_vec_ff[1] <= sq_vec_ff[0];
      end
   end

   // square-root cell chain
   sqrt_tok_type tok [SQRT_STEPS+1];
   assign tok[0].valid = sq_valid_ff[1];
   assign tok[0].vec   = sq_vec_ff[1];
   assign tok[0].rem   = '0;
   assign tok[0].root  = '0;
   assign tok[0].src   = sum_ff;
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      tun_sqrt_cell u_cell (
         .clock, .reset, .advance, .tok_i(tok[g]), .tok_o(tok[g+1]));
   end

   // divider setup: numerator m<<F plus r/2, divisor r (at least 1)
   logic [ROOT_WIDTH-1:0] r_val;
   logic [NW:0] nfull [3];
   logic [3*RW-1:0] rem_init;
   logic [3*NW-1:0] num_init;
   logic [ROOT_WIDTH-1:0] dv [QW+1];
   logic [3*RW-1:0] rem [QW+1];
   logic [3*QW-1:0] quo [QW+1];
   logic [3*NW-1:0] num [QW+1];
   logic [QW:0]     dvalid;
   vec_type         dvec [QW+1];

   // Quotient = floor((m<<F + r/2)/r). m<2^31 and r>=2^30, so it fits in F+2
   // bits; only the low QW numerator bits need a cell each once the upper
   // part (< r) is preloaded as the initial remainder.
   always_comb begin
      r_val = (tok[SQRT_STEPS].root == '0) ? ROOT_WIDTH'(1) : tok[SQRT_STEPS].root;
      nfull[0] = (NW+1)'({tok[SQRT_STEPS].vec.mag_x, {QW{1'b0}}} >> 2) + (NW+1)'(r_val >> 1);
      nfull[1] = (NW+1)'({tok[SQRT_STEPS].vec.mag_y, {QW{1'b0}}} >> 2) + (NW+1)'(r_val >> 1);
      nfull[2] = (NW+1)'({tok[SQRT_STEPS].vec.mag_z, {QW{1'b0}}} >> 2) + (NW+1)'(r_val >> 1);
      for (int k = 0; k < 3; k++) begin
         rem_init[k*RW +: RW] = RW'(nfull[k] >> QW);
         num_init[k*NW +: NW] = {nfull[k][QW-1:0], {(NW-QW){1'b0}}};
      end
   end
   assign rem[0]    = rem_init;
   assign num[0]    = num_init;
   assign quo[0]    = '0;
   assign dv[0]     = r_val;
   assign dvalid[0] = tok[SQRT_STEPS].valid;
   assign dvec[0]   = tok[SQRT_STEPS].vec;
   for (genvar g = 0; g < QW; g++) begin : g_div
      tun_div_cell #(.QW(QW)) u_cell (
         .clock, .reset, .advance,
         .valid_i(dvalid[g]), .rem_i(rem[g]), .quo_i(quo[g]), .num_i(num[g]),
         .div_i(dv[g]), .vec_i(dvec[g]),
         .valid_o(dvalid[g+1]), .rem_o(rem[g+1]), .quo_o(quo[g+1]),
         .num_o(num[g+1]), .div_o(dv[g+1]), .vec_o(dvec[g+1]));
   end

   // clamp, sign, output register
   logic [QW-1:0] lim;
   logic [QW-1:0] qc [3];
   logic [OUT_WIDTH-1:0] comp [3];
   logic [2:0] negs;
   logic [3*OUT_WIDTH:0] out_ff, out_in;
   always_comb begin
      lim  = QW'(1) << OUT_FRAC_BITS;
      negs = {dvec[QW].neg_z, dvec[QW].neg_y, dvec[QW].neg_x};
      for (int k = 0; k < 3; k++) begin
         qc[k] = (quo[QW][k*QW +: QW] > lim) ? lim : quo[QW][k*QW +: QW];
         comp[k] = negs[k] ? OUT_WIDTH'(-{{OUT_WIDTH{1'b0}}, qc[k]})
                           : OUT_WIDTH'({{OUT_WIDTH{1'b0}}, qc[k]});
         if (dvec[QW].degen) comp[k] = '0;
      end
      out_in = {dvec[QW].degen, comp[2], comp[1], comp[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dvalid[QW];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule

// ----- bench/triangle_unit_normal_tb.sv -----
// Self-checking testbench for the triangle unit normal block.
`timescale 1ns / 1ps
module triangle_unit_normal_tb import tun_pkg::*;;

   // Request payload: nine Q8.8 coordinates, point a x in the low bits.
   typedef struct packed {
      logic signed [15:0] cz, cy, cx;
      logic signed [15:0] bz, by_coord, bx;
      logic signed [15:0] az, ay, ax;
   } tri_type;

   // Response payload: Q1.14 normal, x in the low bits, degenerate flag on top.
   typedef struct packed {
      logic                        degenerate;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_x;
   } normal_type;

   localparam int LIMIT_CYCLES = 300000;
   localparam int TAIL_CYCLES  = 100;    // beyond the pipeline depth

   logic clock = 1'b0;
   logic reset = 1'b1;

   tun_stream_if #(.WIDTH($bits(tri_type)))    req_if ();
   tun_stream_if #(.WIDTH($bits(normal_type))) rsp_if ();

   triangle_unit_normal dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   normal_type normals_due[$];   // expected normals, oldest first
   int         fail_count   = 0;
   int         sent_count   = 0;
   int         seen_count   = 0;
   int         degen_count  = 0;
   int         cycle_count  = 0;
   bit         idle_on      = 1'b1;  // random gaps on both sides
   int         hold_cycles  = 0;     // long receiver hold requested

   initial begin
      forever #5 clock = ~clock;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Integer square root, floor, one result bit per step.
   function automatic logic [63:0] floor_root(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] b;
      res = 64'd0;
      b   = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s   = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Unit normal of (c-b) x (a-b), block-normalized then divided by its length.
   function automatic normal_type face_normal(tri_type t);
      normal_type     o;
      longint         v1[3], v2[3], n[3];
      logic [63:0]    m[3], maxm, s, r, q, lim;
      bit             neg[3];
      int             len;
      v1[0] = longint'(t.ax) - longint'(t.bx);
      v1[1] = longint'(t.ay) - longint'(t.by_coord);
      v1[2] = longint'(t.az) - longint'(t.bz);
      v2[0] = longint'(t.cx) - longint'(t.bx);
      v2[1] = longint'(t.cy) - longint'(t.by_coord);
      v2[2] = longint'(t.cz) - longint'(t.bz);
      n[0] = v2[1] * v1[2] - v2[2] * v1[1];
      n[1] = v2[2] * v1[0] - v2[0] * v1[2];
      n[2] = v2[0] * v1[1] - v2[1] * v1[0];
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = n[i] < 0;
         m[i]   = neg[i] ? 64'(-n[i]) : 64'(n[i]);
         if (m[i] > maxm) maxm = m[i];
      end
      o = '0;
      if (maxm == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      len = 0;
      while (maxm != 0) begin
         len++;
         maxm = maxm >> 1;
      end
      for (int i = 0; i < 3; i++) begin
         if (len > 31) m[i] = m[i] >> (len - 31);
         else if (len < 31) m[i] = m[i] << (31 - len);
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = floor_root(s);
      if (r == 0) r = 1;
      lim = 64'd1 << OUT_FRAC_BITS_DEF;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << OUT_FRAC_BITS_DEF) + (r >> 1)) / r;
         if (q > lim) q = lim;
         if (neg[i]) q = 64'd0 - q;
         case (i)
            0: o.normal_x = q[OUT_WIDTH-1:0];
            1: o.normal_y = q[OUT_WIDTH-1:0];
            default: o.normal_z = q[OUT_WIDTH-1:0];
         endcase
      end
      return o;
   endfunction

   // Offer one triangle, after a random gap while idle_on is set; the expectation is queued on accept.
   task automatic send_tri(tri_type t);
      int gap;
      gap = idle_on ? $urandom_range(3) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= t;
      do @(posedge clock); while (!req_if.ready);
      normals_due.push_back(face_normal(t));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (normals_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] any_coord();
      return 16'($urandom);
   endfunction

   // Random triangle: full range, small range, collinear or coincident.
   function automatic tri_type rand_tri();
      tri_type t;
      int      kind, k;
      kind = $urandom_range(9);
      t = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
           any_coord(), any_coord(), any_coord(), any_coord()};
      if (kind < 3) begin
         // Coordinates near the origin keep the cross product short.
         t.ax = 16'($signed(16'($urandom_range(16))) - 8);
         t.ay = 16'($signed(16'($urandom_range(16))) - 8);
         t.az = 16'($signed(16'($urandom_range(16))) - 8);
         t.cx = 16'($signed(16'($urandom_range(16))) - 8);
         t.cy = 16'($signed(16'($urandom_range(16))) - 8);
         t.cz = 16'($signed(16'($urandom_range(16))) - 8);
         t.bx = 16'($signed(16'($urandom_range(16))) - 8);
         t.by_coord = 16'($signed(16'($urandom_range(16))) - 8);
         t.bz = 16'($signed(16'($urandom_range(16))) - 8);
      end else if (kind == 3) begin
         // c on the line through b and a, within range: wrapped values are fine too.
         k = int'($urandom_range(6)) - 3;
         t.ax = t.bx + 16'($signed(16'($urandom_range(200))) - 100);
         t.ay = t.by_coord + 16'($signed(16'($urandom_range(200))) - 100);
         t.az = t.bz + 16'($signed(16'($urandom_range(200))) - 100);
         t.cx = t.bx + 16'(k * (t.ax - t.bx));
         t.cy = t.by_coord + 16'(k * (t.ay - t.by_coord));
         t.cz = t.bz + 16'(k * (t.az - t.bz));
      end else if (kind == 4) begin
         if ($urandom_range(1)) {t.ax, t.ay, t.az} = {t.bx, t.by_coord, t.bz};
         else {t.cx, t.cy, t.cz} = {t.ax, t.ay, t.az};
      end
      return t;
   endfunction

   // Receiver: random gap before each transaction, or a long hold on request.
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            gap = idle_on ? $urandom_range(3) : 0;
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Response checker: compare every accepted transaction with the oldest due.
   always @(posedge clock) begin
      normal_type got, due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (normals_due.size() == 0) begin
            $error("unexpected response %h", got);
            fail_count++;
         end else begin
            due = normals_due.pop_front();
            seen_count++;
            if (due.degenerate) degen_count++;
            if (got.normal_x !== due.normal_x) begin
               $error("normal_x expected %0d got %0d", due.normal_x, got.normal_x);
               fail_count++;
            end
            if (got.normal_y !== due.normal_y) begin
               $error("normal_y expected %0d got %0d", due.normal_y, got.normal_y);
               fail_count++;
            end
            if (got.normal_z !== due.normal_z) begin
               $error("normal_z expected %0d got %0d", due.normal_z, got.normal_z);
               fail_count++;
            end
            if (got.degenerate !== due.degenerate) begin
               $error("degenerate expected %0b got %0b", due.degenerate, got.degenerate);
               fail_count++;
            end
         end
      end
   end

   // Extremes, axis-aligned faces, degenerate shapes.
   task automatic test_directed();
      tri_type t;
      send_tri('0);                                   // all coincident
      t = '0; t.ax = 16'sd256; t.cy = 16'sd256;       // unit right triangle in xy
      send_tri(t);
      t = '0; t.ay = 16'sd256; t.cz = 16'sd256;       // yz plane
      send_tri(t);
      t = '0; t.az = 16'sd256; t.cx = 16'sd256;       // zx plane
      send_tri(t);
      t = '0; t.cx = 16'sd256; t.ay = 16'sd256;       // flipped winding
      send_tri(t);
      t = '0; t.ax = 16'sd1; t.cy = 16'sd1;           // smallest nonzero area
      send_tri(t);
      t = {9{16'sh7FFF}}; t.bx = 16'sh8000; t.by_coord = 16'sh8000; t.bz = 16'sh8000;
      t.ay = 16'sh8000; t.cz = 16'sh8000;             // largest differences
      send_tri(t);
      t = {9{16'sh8000}}; t.ax = 16'sh7FFF; t.cy = 16'sh7FFF;
      send_tri(t);
      t = {9{16'sh7FFF}}; t.ax = 16'sh8000; t.cy = 16'sh8000; t.bz = 16'sh8000;
      send_tri(t);
      t = {9{16'hFFFF}};                              // coincident at -1 lsb
      send_tri(t);
      t = '0; t.ax = 16'sd256; t.ay = 16'sd256; t.az = 16'sd256;
      t.cx = -16'sd512; t.cy = -16'sd512; t.cz = -16'sd512;  // collinear
      send_tri(t);
      t = '0; t.ax = 16'sd100; t.ay = 16'sd100; t.cx = 16'sd100; t.cy = -16'sd100;
      t.az = 16'sd1; t.cz = 16'sd1;                   // diagonal components
      send_tri(t);
      t = '0; t.ax = 16'sd1; t.ay = 16'sd1; t.cy = 16'sd1; t.cz = 16'sd1;
      send_tri(t);                                    // all three components nonzero
      t = '0; t.ax = 16'sh7FFF; t.cy = 16'sd1;        // very uneven sides
      send_tri(t);
      wait_drained();
   endtask

   task automatic test_random(int count);
      repeat (count) send_tri(rand_tri());
      wait_drained();
   endtask

   // Back-to-back stream with no idling at all.
   task automatic test_full_rate(int count);
      idle_on = 1'b0;
      repeat (count) send_tri(rand_tri());
      wait_drained();
      idle_on = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering, so the pipe fills.
   task automatic test_backpressure(int count);
      idle_on     = 1'b0;
      hold_cycles = 200;
      repeat (count) send_tri(rand_tri());
      idle_on = 1'b1;
      wait_drained();
   endtask

   // Sender stops mid-stream until every due response has come back.
   task automatic test_drain_pause(int count);
      repeat (count) send_tri(rand_tri());
      wait_drained();
      repeat (count) send_tri(rand_tri());
      wait_drained();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(1200);
      test_full_rate(200);
      test_backpressure(150);
      test_drain_pause(75);

      $display("Covered %0d triangles (%0d degenerate), %0d responses checked,",
               sent_count, degen_count, seen_count);
      $display("with random gaps, full-rate bursts, a long receiver hold and a drain pause.");
      if (fail_count == 0 && normals_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- files.f -----
src/tun_pkg.sv
src/tun_stream_if.sv
src/tun_sqrt_cell.sv
src/tun_div_cell.sv
src/tun_front.sv
src/triangle_unit_normal.sv
bench/triangle_unit_normal_tb.sv
